### rtl/core/picb_pkg.sv
`default_nettype none

package picb_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  localparam int AIM_WIDTH = 16;
  localparam int FRAC_BITS = AIM_WIDTH - 1;
  localparam int COS_WIDTH = 16;
  localparam int SHAPE_WIDTH = 2;
  localparam int RADIUS_WIDTH = 23;
  localparam int LENGTH_WIDTH = 23;
  localparam int BWIDTH_WIDTH = 24;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 24;

  // squared magnitudes of the config and aim quantities, and the box length scaled by the aim fraction bits
  localparam int R2_WIDTH = 2 * RADIUS_WIDTH;
  localparam int BW2_WIDTH = 2 * BWIDTH_WIDTH;
  localparam int C2_WIDTH = 2 * COS_WIDTH - 1;
  localparam int SQA_WIDTH = 2 * AIM_WIDTH - 1;
  localparam int AIM2_WIDTH = 2 * AIM_WIDTH;
  localparam int BL15_WIDTH = LENGTH_WIDTH + FRAC_BITS;

  localparam logic signed [COS_WIDTH-1:0] COS_RESET = 16'sh7FFF;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_AREA_SHAPE = 3'd0,
    REG_REACH_RADIUS = 3'd1,
    REG_BOX_LENGTH = 3'd2,
    REG_BOX_WIDTH = 3'd3,
    REG_CONE_HALF_COSINE = 3'd4
  } reg_index_t;

  localparam logic [SHAPE_WIDTH-1:0] SHAPE_CIRCLE = 2'd0;
  localparam logic [SHAPE_WIDTH-1:0] SHAPE_CONE = 2'd1;
  localparam logic [SHAPE_WIDTH-1:0] SHAPE_BOX = 2'd2;

endpackage

`default_nettype wire

### rtl/core/picb_mul.sv
`default_nettype none

module picb_mul #(
  parameter int A_WIDTH = 32,
  parameter int B_WIDTH = 32
) (
  input  logic                       clk,
  input  logic [A_WIDTH-1:0]         a,
  input  logic [B_WIDTH-1:0]         b,
  output logic [A_WIDTH+B_WIDTH-1:0] p
);

  localparam int AL = (A_WIDTH + 1) / 2;
  localparam int AH = A_WIDTH - AL;
  localparam int BL = (B_WIDTH + 1) / 2;
  localparam int BH = B_WIDTH - BL;
  localparam int PW = A_WIDTH + B_WIDTH;

  logic [AL+BL-1:0] p_ll;
  logic [AL+BH-1:0] p_lh;
  logic [AH+BL-1:0] p_hl;
  logic [AH+BH-1:0] p_hh;

  // partial products, then their sum
  always_ff @(posedge clk) begin
    p_ll <= a[AL-1:0] * b[BL-1:0];
    p_lh <= a[AL-1:0] * b[B_WIDTH-1:BL];
    p_hl <= a[A_WIDTH-1:AL] * b[BL-1:0];
    p_hh <= a[A_WIDTH-1:AL] * b[B_WIDTH-1:BL];
    p <= PW'(p_ll) + (PW'(p_lh) << BL) + (PW'(p_hl) << AL) + (PW'(p_hh) << (AL + BL));
  end

endmodule

`default_nettype wire

### rtl/core/point_in_circle_cone_box_test.sv
`default_nettype none

// channel   direction  handshake           payload
// item in   in         start / busy        source_x, source_y, aim_x, aim_y, target_x, target_y
// result    out        done (one cycle)    inside_res
// config    in         cfg_we              cfg_index, cfg_data
//
// one item per cycle; each result passes through eight register stages,
// two of them the split wide multipliers
// busy stays low: every start is taken
// rst clears the valid bits and the config registers to their reset values
// no stalls: the receiver takes every result in its one done cycle

module point_in_circle_cone_box_test
  import picb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] source_x,
  input  logic signed [COORD_WIDTH-1:0] source_y,
  input  logic signed [AIM_WIDTH-1:0]   aim_x,
  input  logic signed [AIM_WIDTH-1:0]   aim_y,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  output logic                          done,
  output logic                          inside_res,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = DW + AIM_WIDTH;
  localparam int SW = PW + 1;
  localparam int AMW = SW - 1;
  localparam int TWW = SW;
  localparam int SQW = 2 * COORD_WIDTH + 1;
  localparam int D2W = SQW + 1;
  localparam int A2W = 2 * AMW;
  localparam int L2W = 2 * TWW;
  localparam int CRW = D2W + C2_WIDTH;
  localparam int BRW = BW2_WIDTH + AIM2_WIDTH;
  localparam int BLCMPW = (AMW > BL15_WIDTH) ? AMW : BL15_WIDTH;
  localparam int R2CMPW = (D2W > R2_WIDTH) ? D2W : R2_WIDTH;
  localparam int CNCMPW = (CRW > A2W) ? CRW : A2W;
  localparam int BXCMPW = (BRW > L2W) ? BRW : L2W;

  // config registers
  logic [SHAPE_WIDTH-1:0]         area_shape;
  logic [RADIUS_WIDTH-1:0]        reach_radius;
  logic [LENGTH_WIDTH-1:0]        box_length;
  logic [BWIDTH_WIDTH-1:0]        box_width;
  logic signed [COS_WIDTH-1:0]    cone_half_cosine;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_shape <= SHAPE_CIRCLE;
      reach_radius <= '0;
      box_length <= '0;
      box_width <= '0;
      cone_half_cosine <= COS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AREA_SHAPE:       area_shape <= cfg_data[SHAPE_WIDTH-1:0];
        REG_REACH_RADIUS:     reach_radius <= cfg_data[RADIUS_WIDTH-1:0];
        REG_BOX_LENGTH:       box_length <= cfg_data[LENGTH_WIDTH-1:0];
        REG_BOX_WIDTH:        box_width <= cfg_data[BWIDTH_WIDTH-1:0];
        REG_CONE_HALF_COSINE: cone_half_cosine <= cfg_data[COS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits
  logic v1, v2, v3, v4, v5, v6, v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      done <= v7;
    end
  end

  // stage 1: input registers
  logic signed [COORD_WIDTH-1:0] sx1, sy1, tx1, ty1;
  logic signed [AIM_WIDTH-1:0]   ax1, ay1;

  always_ff @(posedge clk) begin
    sx1 <= source_x;
    sy1 <= source_y;
    tx1 <= target_x;
    ty1 <= target_y;
    ax1 <= aim_x;
    ay1 <= aim_y;
  end

  // stage 2: displacement
  logic signed [DW-1:0]        dx2, dy2;
  logic signed [AIM_WIDTH-1:0] ax2, ay2;

  always_ff @(posedge clk) begin
    dx2 <= {tx1[COORD_WIDTH-1], tx1} - {sx1[COORD_WIDTH-1], sx1};
    dy2 <= {ty1[COORD_WIDTH-1], ty1} - {sy1[COORD_WIDTH-1], sy1};
    ax2 <= ax1;
    ay2 <= ay1;
  end

  // stage 3: products
  logic signed [PW-1:0]           pax_c, pay_c, qxy_c, qyx_c;
  logic signed [2*DW-1:0]         sqx_c, sqy_c;
  logic signed [2*AIM_WIDTH-1:0]  sax_c, say_c;
  logic signed [2*COS_WIDTH-1:0]  c2_c;

  assign pax_c = ax2 * dx2;
  assign pay_c = ay2 * dy2;
  assign qxy_c = ax2 * dy2;
  assign qyx_c = ay2 * dx2;
  assign sqx_c = dx2 * dx2;
  assign sqy_c = dy2 * dy2;
  assign sax_c = ax2 * ax2;
  assign say_c = ay2 * ay2;
  assign c2_c = cone_half_cosine * cone_half_cosine;

  logic signed [PW-1:0]    pax3, pay3, qxy3, qyx3;
  logic [SQW-1:0]          sqx3, sqy3;
  logic [SQA_WIDTH-1:0]    sax3, say3;
  logic                    zero3;
  logic [R2_WIDTH-1:0]     r2q;
  logic [BW2_WIDTH-1:0]    bw2q;
  logic [C2_WIDTH-1:0]     c2q;

  always_ff @(posedge clk) begin
    pax3 <= pax_c;
    pay3 <= pay_c;
    qxy3 <= qxy_c;
    qyx3 <= qyx_c;
    sqx3 <= sqx_c[SQW-1:0];
    sqy3 <= sqy_c[SQW-1:0];
    sax3 <= sax_c[SQA_WIDTH-1:0];
    say3 <= say_c[SQA_WIDTH-1:0];
    zero3 <= (dx2 == '0) && (dy2 == '0);
    // the user must keep config steady while items are in flight; the block does not enforce it
    r2q <= reach_radius * reach_radius;
    bw2q <= box_width * box_width;
    c2q <= c2_c[C2_WIDTH-1:0];
  end

  // stage 4: sums
  logic [D2W-1:0]         d2_4;
  logic signed [SW-1:0]   a4, side4;
  logic [AIM2_WIDTH-1:0]  aim2_4;
  logic                   zero4;

  always_ff @(posedge clk) begin
    d2_4 <= D2W'(sqx3) + D2W'(sqy3);
    a4 <= SW'(pax3) + SW'(pay3);
    side4 <= SW'(qxy3) - SW'(qyx3);
    aim2_4 <= AIM2_WIDTH'(sax3) + AIM2_WIDTH'(say3);
    zero4 <= zero3;
  end

  // stage 5: magnitudes and range checks
  logic signed [SW-1:0] a_neg_c, side_neg_c;
  logic [AMW-1:0]       am_c, sm_c;
  logic                 ale_c, dle_c;

  assign a_neg_c = -a4;
  assign side_neg_c = -side4;
  assign am_c = a4[SW-1] ? a_neg_c[AMW-1:0] : a4[AMW-1:0];
  assign sm_c = side4[SW-1] ? side_neg_c[AMW-1:0] : side4[AMW-1:0];
  assign ale_c = BLCMPW'(a4[AMW-1:0]) <= BLCMPW'({box_length, FRAC_BITS'(0)});
  assign dle_c = R2CMPW'(d2_4) <= R2CMPW'(r2q);

  logic [AMW-1:0]        am5;
  logic [TWW-1:0]        tw5;
  logic [D2W-1:0]        d2_5;
  logic [AIM2_WIDTH-1:0] aim2_5;
  logic                  zero5, anon5, ale5, dle5;

  always_ff @(posedge clk) begin
    am5 <= am_c;
    tw5 <= {sm_c, 1'b0};
    d2_5 <= d2_4;
    aim2_5 <= aim2_4;
    zero5 <= zero4;
    anon5 <= !a4[SW-1];
    ale5 <= ale_c;
    dle5 <= dle_c;
  end

  // stages 6 and 7: wide squares and products
  logic [A2W-1:0] a2_7;
  logic [L2W-1:0] l2_7;
  logic [CRW-1:0] cr_7;
  logic [BRW-1:0] br_7;

  picb_mul #(.A_WIDTH(AMW), .B_WIDTH(AMW)) u_mul_a2 (
    .clk (clk),
    .a   (am5),
    .b   (am5),
    .p   (a2_7)
  );

  picb_mul #(.A_WIDTH(TWW), .B_WIDTH(TWW)) u_mul_side2 (
    .clk (clk),
    .a   (tw5),
    .b   (tw5),
    .p   (l2_7)
  );

  picb_mul #(.A_WIDTH(D2W), .B_WIDTH(C2_WIDTH)) u_mul_cone (
    .clk (clk),
    .a   (d2_5),
    .b   (c2q),
    .p   (cr_7)
  );

  picb_mul #(.A_WIDTH(BW2_WIDTH), .B_WIDTH(AIM2_WIDTH)) u_mul_box (
    .clk (clk),
    .a   (bw2q),
    .b   (aim2_5),
    .p   (br_7)
  );

  logic zero6, anon6, ale6, dle6;
  logic zero7, anon7, ale7, dle7;

  always_ff @(posedge clk) begin
    zero6 <= zero5;
    anon6 <= anon5;
    ale6 <= ale5;
    dle6 <= dle5;
    zero7 <= zero6;
    anon7 <= anon6;
    ale7 <= ale6;
    dle7 <= dle6;
  end

  // stage 8: decision
  logic cone_ok, box_ok, shape_ok;

  assign cone_ok = dle7 && (cone_half_cosine[COS_WIDTH-1]
                            ? (anon7 || (CNCMPW'(a2_7) <= CNCMPW'(cr_7)))
                            : (anon7 && (CNCMPW'(cr_7) <= CNCMPW'(a2_7))));
  assign box_ok = anon7 && ale7 && (BXCMPW'(l2_7) <= BXCMPW'(br_7));

  always_comb begin
    case (area_shape)
      SHAPE_CONE: shape_ok = cone_ok;
      SHAPE_BOX:  shape_ok = box_ok;
      default:    shape_ok = dle7;
    endcase
  end

  always_ff @(posedge clk) begin
    inside_res <= zero7 || shape_ok;
  end

  // every item taken gives its result, shown by done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 done)
    else $error("item taken without a result after the pipeline latency");

  // a target on the source is always inside
  a_coincident: assert property (@(posedge clk) disable iff (rst)
    (v3 && zero3) |-> ##5 (done && inside_res))
    else $error("coincident target not reported inside");

  // no result without an item taken
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v7))
    else $error("result strobe without an item in flight");

endmodule

`default_nettype wire
